/* design/assert_macros.svh */
// Assertion macros for the RTL files.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check an implication on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`endif

/* design/sceg_pkg.sv */
// Package for the softmax cross-entropy gradient block: constants, codes, types.
// No dependencies.
package sceg_pkg;
  localparam int LabelBitsDefault = 16;
  localparam logic [39:0] TallyMax = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CfgReduction = 2'd0,
    CfgIgnore    = 2'd1,
    CfgWeights   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RedNone = 2'd0,
    RedSum  = 2'd1,
    RedMean = 2'd2
  } red_mode_e;

  typedef enum logic [3:0] {
    StIdle,
    StDiv,
    StExpMul,
    StExpInt,
    StExpShift,
    StMulW,
    StMulS,
    StAdd,
    StOut
  } state_e;

  typedef struct packed {
    logic        func;
    logic        start_req;
    logic [15:0] label;
    logic [15:0] class_index;
    logic signed [23:0] ln_prob;
    logic [23:0] label_weight;
    logic signed [23:0] upstream_grad;
    logic signed [23:0] bias_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] logit_grad;
    logic               saturated;
  } out_item_t;

  // 2^(i/16) in Q16
  function automatic logic [17:0] pow2_tab(input logic [4:0] i);
    logic [17:0] v;
    case (i)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction
endpackage

/* design/sceg_stream_if.sv */
// Valid/ready channel carrying one payload type.
// Depends on nothing; the payload type is a parameter.
interface sceg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/sceg_divider.sv */
// Restoring divider, one quotient bit per cycle, for the mean scale.
// No dependencies; standalone arithmetic.
module sceg_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [39:0] num_i,
  input  logic [39:0] den_i,
  output logic        done_o,
  output logic [39:0] quot_o
);
  logic [39:0] rem_q, rem_d, quot_q, quot_d, den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [40:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quot_q[39]} - {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      quot_d = num_i;
      cnt_d  = 6'd40;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift one dividend bit in, subtract if it fits
      if (!trial[40]) begin
        rem_d = trial[39:0];
      end else begin
        rem_d = {rem_q[38:0], quot_q[39]};
      end
      quot_d = {quot_q[38:0], ~trial[40]};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = busy_q && (cnt_q == 6'd1);
  assign quot_o = quot_d;
endmodule

/* design/softmax_cross_entropy_gradient.sv */
// Top level of the softmax cross-entropy gradient block.
// Depends on sceg_pkg, sceg_stream_if, sceg_divider and assert_macros.svh.
//
//   channel  | dir | payload
//   in_if    | in  | func, start_req, label, class_index, ln_prob,
//            |     | label_weight, upstream_grad, bias_value
//   out_if   | out | logit_grad, saturated
//
// A tally request passes through the add and divide states. An element request
// uses one shared 35x33 signed multiplier (exp scale, interpolation, weight, scale)
// and waits once per batch in the divide state while the mean scale is divided by the tally.
// Reset is asynchronous active low and clears tally and scale flags.
// The result waits in the output register; the next element request holds
// in its output state until that register is free.
`include "assert_macros.svh"
module softmax_cross_entropy_gradient #(
  parameter int LABEL_BITS = sceg_pkg::LabelBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_data_i,
  sceg_stream_if.sink   in_if,
  sceg_stream_if.source out_if
);
  localparam int LB = (LABEL_BITS < 16) ? LABEL_BITS : 16;

  sceg_pkg::state_e state_q, state_d;
  sceg_pkg::in_item_t it_q;

  logic [1:0]  red_q;
  logic signed [16:0] ign_q;
  logic        usew_q;
  logic [39:0] tally_q, tally_d;
  logic signed [31:0] mscale_q, mscale_d;
  logic        sready_q, sready_d, sclip_q, sclip_d;

  logic signed [33:0] acc_q, acc_d;   // exp value, then products
  logic [4:0]  k_q, k_d;
  logic [31:0] u_q, u_d;
  logic signed [31:0] res_q, res_d;
  logic        sat_q, sat_d;
  logic        ovalid_q, ovalid_d;

  // shared multiplier
  logic signed [34:0] ma;
  logic signed [32:0] mb;
  logic signed [67:0] mp;
  assign mp = ma * mb;

  logic [LB-1:0] lab, cls;
  logic        ignored, mean, lab_eq;
  logic [23:0] wgt;
  logic [23:0] dy_mag;
  logic        div_start, div_done;
  logic [39:0] quot;
  logic [40:0] tsum;
  logic [16:0] w17;
  logic [4:0]  ti;
  logic [17:0] t0, t1;
  logic [67:0] mag, rnd;
  logic signed [33:0] sum34;

  assign lab     = it_q.label[LB-1:0];
  assign cls     = it_q.class_index[LB-1:0];
  assign ignored = ($signed({1'b0, 16'(lab)}) == ign_q);
  assign mean    = red_q[1];
  assign lab_eq  = (lab == cls);
  assign wgt     = usew_q ? it_q.label_weight : 24'd65536;
  assign dy_mag  = it_q.upstream_grad[23] ? 24'(-it_q.upstream_grad)
                                          : it_q.upstream_grad;
  assign tsum    = {1'b0, tally_q} + {17'd0, wgt};
  assign w17     = 17'd65536 - {1'b0, u_q[15:0]};
  assign ti      = w17[16:12];
  assign t0      = sceg_pkg::pow2_tab(ti);
  assign t1      = sceg_pkg::pow2_tab(ti + 5'd1);

  sceg_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({dy_mag, 16'd0} + {1'b0, tally_q[39:1]}),
    .den_i  (tally_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  always_comb begin
    state_d   = state_q;
    tally_d   = tally_q;
    mscale_d  = mscale_q;
    sready_d  = sready_q;
    sclip_d   = sclip_q;
    acc_d     = acc_q;
    k_d       = k_q;
    u_d       = u_q;
    res_d     = res_q;
    sat_d     = sat_q;
    ovalid_d  = ovalid_q;
    div_start = 1'b0;
    ma        = '0;
    mb        = '0;
    mag       = '0;
    rnd       = '0;
    sum34     = '0;
    if (out_if.valid && out_if.ready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      sceg_pkg::StIdle: begin
        // clear the divider launch mark left by the exp shift
        k_d = '0;
        if (in_if.valid) begin
          state_d = in_if.data.func ? sceg_pkg::StDiv : sceg_pkg::StAdd;
        end
      end
      sceg_pkg::StDiv: begin
        if (it_q.func == 1'b0) begin
          // tally request
          if (it_q.start_req) begin
            tally_d = ignored ? 40'd0 : 40'(wgt);
          end else if (!ignored) begin
            tally_d = tsum[40] ? sceg_pkg::TallyMax : tsum[39:0];
          end
          sready_d = 1'b0;
          state_d  = sceg_pkg::StIdle;
        end else if (!mean || sready_q) begin
          state_d = sceg_pkg::StExpMul;
        end else if (tally_q == 40'd0) begin
          mscale_d = 32'(it_q.upstream_grad);
          sclip_d  = 1'b0;
          sready_d = 1'b1;
          state_d  = sceg_pkg::StExpMul;
        end else if (!div_done) begin
          // hold until the quotient is in
          div_start = (k_q == 5'd0);
          k_d       = 5'd1;
        end else begin
          k_d = 5'd0;
          if (it_q.upstream_grad[23]) begin
            sclip_d  = quot > 40'h80000000;
            mscale_d = (quot > 40'h80000000) ? 32'sh80000000 : -$signed(quot[31:0]);
          end else begin
            sclip_d  = quot > 40'h7FFFFFFF;
            mscale_d = (quot > 40'h7FFFFFFF) ? 32'sh7FFFFFFF : $signed(quot[31:0]);
          end
          sready_d = 1'b1;
          state_d  = sceg_pkg::StExpMul;
        end
      end
      sceg_pkg::StExpMul: begin
        // u = round(-x * log2e)
        ma  = it_q.ln_prob[23] ? 35'(-it_q.ln_prob) : 35'sd0;
        mb  = 33'sd94548;
        u_d = 32'((mp + 68'sd32768) >>> 16);
        state_d = sceg_pkg::StExpInt;
      end
      sceg_pkg::StExpInt: begin
        ma    = 35'($signed({1'b0, t1 - t0}));
        mb    = 33'($signed({1'b0, w17[11:0]}));
        acc_d = 34'($signed({1'b0, t0})) + 34'((mp + 68'sd2048) >>> 12);
        if (ti[4]) begin
          acc_d = 34'sd131072;
        end
        k_d   = u_q[20:16];
        state_d = sceg_pkg::StExpShift;
      end
      sceg_pkg::StExpShift: begin
        if (u_q[31:16] >= 16'd20) begin
          acc_d = '0;
        end else begin
          acc_d = 34'((acc_q + (34'sd1 <<< k_q)) >>> (k_q + 5'd1));
        end
        acc_d = acc_d - (lab_eq ? 34'sd65536 : 34'sd0);
        state_d = sceg_pkg::StMulW;
      end
      sceg_pkg::StMulW: begin
        ma    = 35'(acc_q);
        mb    = 33'($signed({1'b0, wgt}));
        mag   = mp[67] ? 68'(-mp) : 68'(mp);
        rnd   = (mag + 68'd32768) >> 16;
        acc_d = mp[67] ? -34'(rnd) : 34'(rnd);
        state_d = sceg_pkg::StMulS;
      end
      sceg_pkg::StMulS: begin
        ma    = 35'(acc_q);
        mb    = mean ? 33'(mscale_q) : 33'(it_q.upstream_grad);
        mag   = mp[67] ? 68'(-mp) : 68'(mp);
        rnd   = (mag + 68'd32768) >> 16;
        acc_d = mp[67] ? -34'(rnd[33:0]) : 34'(rnd[33:0]);
        // clamp well outside the 32-bit range so the bias add cannot wrap
        if (rnd[67:32] != '0) begin
          acc_d = mp[67] ? -34'sh1_0000_0000 : 34'sh1_0000_0000;
        end
        state_d = sceg_pkg::StOut;
      end
      sceg_pkg::StOut: begin
        if (!ovalid_q || out_if.ready) begin
          if (ignored) begin
            res_d = 32'(it_q.bias_value);
            sat_d = 1'b0;
          end else begin
            sum34 = acc_q + 34'(it_q.bias_value);
            sat_d = mean && sclip_q;
            if (sum34 > 34'sh0_7FFF_FFFF) begin
              res_d = 32'sh7FFFFFFF;
              sat_d = 1'b1;
            end else if (sum34 < -34'sh0_8000_0000) begin
              res_d = 32'sh80000000;
              sat_d = 1'b1;
            end else begin
              res_d = sum34[31:0];
            end
          end
          ovalid_d = 1'b1;
          state_d  = sceg_pkg::StIdle;
        end
      end
      sceg_pkg::StAdd: begin
        state_d = sceg_pkg::StDiv;
      end
      default: state_d = sceg_pkg::StIdle;
    endcase
  end

  assign in_if.ready      = (state_q == sceg_pkg::StIdle);
  assign out_if.valid     = ovalid_q;
  assign out_if.data.logit_grad = res_q;
  assign out_if.data.saturated  = sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sceg_pkg::StIdle;
      red_q    <= sceg_pkg::RedMean;
      ign_q    <= -17'sd1;
      usew_q   <= 1'b0;
      tally_q  <= '0;
      mscale_q <= '0;
      sready_q <= 1'b0;
      sclip_q  <= 1'b0;
      ovalid_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      tally_q  <= tally_d;
      mscale_q <= mscale_d;
      sready_q <= sready_d;
      sclip_q  <= sclip_d;
      ovalid_q <= ovalid_d;
      k_q      <= k_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sceg_pkg::CfgReduction: red_q  <= cfg_data_i[1:0];
          sceg_pkg::CfgIgnore:    ign_q  <= $signed(cfg_data_i);
          sceg_pkg::CfgWeights:   usew_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      it_q <= in_if.data;
    end
    acc_d_reg: begin
      acc_q <= acc_d;
      u_q   <= u_d;
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  `ASSERT_IMP(a_busy_no_ready, clk_i, rst_ni, state_q != sceg_pkg::StIdle, !in_if.ready, "ready while busy")
  `ASSERT_IMP(a_out_hold, clk_i, rst_ni, out_if.valid && !out_if.ready, ##1 out_if.valid, "result dropped")
  `ASSERT_CLK(a_tally_clr, clk_i, rst_ni, (state_q == sceg_pkg::StDiv && !it_q.func) |=> !sready_q, "scale kept after tally")
endmodule
